### rtl/core/integer_number_theory_unit_defines.svh
// assertion macros used by intu_alu
`ifndef INTEGER_NUMBER_THEORY_UNIT_DEFINES_SVH
`define INTEGER_NUMBER_THEORY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define INTU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define INTU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  `INTU_ASSERT(label, clk, rst_n, (pre) |=> (post), msg)
`else
`define INTU_ASSERT(label, clk, rst_n, prop, msg)
`define INTU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

### rtl/core/intu_pkg.sv
`default_nettype none
package intu_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned MODE_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUOT = 3'd0,
    MODE_REM  = 3'd1,
    MODE_MOD  = 3'd2,
    MODE_GCD  = 3'd3,
    MODE_LCM  = 3'd4,
    MODE_POW  = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_GCD_CHK,
    S_GCD_DIV,
    S_LCM_MUL,
    S_LCM_DIV,
    S_POW_CHK,
    S_POW_RMUL,
    S_POW_SHIFT,
    S_POW_XMUL,
    S_DONE
  } state_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  // request from the sequencer to the shared unit
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // status from the shared unit
  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage
`default_nettype wire

### rtl/core/intu_if.sv
`default_nettype none
// input channel: operation code and two operands
interface intu_in_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [2:0]   mode;
  logic [W-1:0] operand_a;
  logic [W-1:0] operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

// output channel: one result
interface intu_out_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface
`default_nettype wire

### rtl/core/integer_number_theory_unit.sv
// quotient, remainder, modulo: the shared unit divides the magnitudes, the signed result is registered in S_DIV
// a zero divisor or a trivial operand gives a valid result in the cycle after the transfer
// gcd runs Euclid steps, each a divide on the shared unit, lcm adds one multiply and divide
// power does up to two multiplies per exponent bit on the shared unit
// one item at a time: a new item is taken only in idle, after the last result has been taken
// reset: asynchronous active low, sequencer returns to idle, no result pending
`default_nettype none
module integer_number_theory_unit import intu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  intu_in_if.sink  in_i,
  intu_out_if.source out_o
);

  localparam int unsigned W = DATA_WIDTH;

  state_e       state_q, state_d;
  logic [2:0]   mode_q, mode_d;
  logic [W-1:0] a_q, a_d, b_q, b_d;
  logic [W-1:0] x_q, x_d, y_q, y_d;
  logic [W-1:0] p_q, p_d, acc_q, acc_d, res_q, res_d;

  alu_req_t     alu_req;
  alu_sts_t     alu_sts;
  logic [W-1:0] alu_x, alu_y, alu_lo, alu_rem;

  logic         in_fire;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_fire = in_i.valid && (state_q == S_IDLE);

  intu_alu #(.W(W)) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .x_i   (alu_x),
    .y_i   (alu_y),
    .sts_o (alu_sts),
    .lo_o  (alu_lo),
    .rem_o (alu_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (mode_e'(in_i.mode))
            MODE_QUOT, MODE_REM, MODE_MOD:
              state_d = (in_i.operand_b == '0) ? S_DONE : S_DIV;
            MODE_GCD: state_d = S_GCD_CHK;
            MODE_LCM:
              state_d = (in_i.operand_a == '0 || in_i.operand_b == '0) ? S_DONE : S_GCD_CHK;
            MODE_POW:
              state_d = (in_i.operand_b == '0 || in_i.operand_b[W-1] ||
                         in_i.operand_a == '0) ? S_DONE : S_POW_CHK;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIV:       if (alu_sts.done) state_d = S_DONE;
      S_GCD_CHK: begin
        if (y_q != '0)                  state_d = S_GCD_DIV;
        else if (mode_q == MODE_GCD)    state_d = S_DONE;
        else                            state_d = S_LCM_MUL;
      end
      S_GCD_DIV:   if (alu_sts.done) state_d = S_GCD_CHK;
      S_LCM_MUL:   if (alu_sts.done) state_d = S_LCM_DIV;
      S_LCM_DIV:   if (alu_sts.done) state_d = S_DONE;
      S_POW_CHK:   state_d = p_q[0] ? S_POW_RMUL : S_POW_SHIFT;
      S_POW_RMUL:  if (alu_sts.done) state_d = S_POW_SHIFT;
      S_POW_SHIFT: state_d = (p_q[W-1:1] == '0) ? S_DONE : S_POW_XMUL;
      S_POW_XMUL:  if (alu_sts.done) state_d = S_POW_CHK;
      S_DONE:      if (out_o.ready) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    mode_d  = mode_q;
    a_d     = a_q;
    b_d     = b_q;
    x_d     = x_q;
    y_d     = y_q;
    p_d     = p_q;
    acc_d   = acc_q;
    res_d   = res_q;
    alu_req = '{start: 1'b0, op: ALU_DIV};
    alu_x   = x_q;
    alu_y   = y_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d = in_i.mode;
          a_d    = in_i.operand_a;
          b_d    = in_i.operand_b;
          x_d    = mag(in_i.operand_a);
          y_d    = mag(in_i.operand_b);
          res_d  = '0;
          unique case (mode_e'(in_i.mode))
            MODE_QUOT, MODE_REM, MODE_MOD: begin
              alu_req = '{start: (in_i.operand_b != '0), op: ALU_DIV};
              alu_x   = mag(in_i.operand_a);
              alu_y   = mag(in_i.operand_b);
            end
            MODE_POW: begin
              if (in_i.operand_b == '0) res_d = W'(1);
              acc_d = W'(1);
              x_d   = in_i.operand_a;
              p_d   = in_i.operand_b;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (alu_sts.done) begin
          unique case (mode_e'(mode_q))
            MODE_QUOT: res_d = (a_q[W-1] != b_q[W-1]) ? (~alu_lo + 1'b1) : alu_lo;
            MODE_REM:  res_d = a_q[W-1] ? (~alu_rem + 1'b1) : alu_rem;
            default: begin
              res_d = a_q[W-1] ? (~alu_rem + 1'b1) : alu_rem;
              if (alu_rem != '0 && a_q[W-1] != b_q[W-1])
                res_d = (a_q[W-1] ? (~alu_rem + 1'b1) : alu_rem) + b_q;
            end
          endcase
        end
      end
      S_GCD_CHK: begin
        if (y_q != '0) begin
          alu_req = '{start: 1'b1, op: ALU_DIV};
        end else if (mode_q == MODE_GCD) begin
          res_d = x_q;
        end else begin
          acc_d   = x_q;
          alu_req = '{start: 1'b1, op: ALU_MUL};
          alu_x   = a_q;
          alu_y   = b_q;
        end
      end
      S_GCD_DIV: begin
        if (alu_sts.done) begin
          x_d = y_q;
          y_d = alu_rem;
        end
      end
      S_LCM_MUL: begin
        alu_req = '{start: alu_sts.done, op: ALU_DIV};
        alu_x   = mag(alu_lo);
        alu_y   = acc_q;
      end
      S_LCM_DIV: if (alu_sts.done) res_d = alu_lo;
      S_POW_CHK: begin
        alu_req = '{start: p_q[0], op: ALU_MUL};
        alu_x   = acc_q;
        alu_y   = x_q;
      end
      S_POW_RMUL: if (alu_sts.done) acc_d = alu_lo;
      S_POW_SHIFT: begin
        p_d = {1'b0, p_q[W-1:1]};
        if (p_q[W-1:1] == '0) res_d = acc_q;
        alu_req = '{start: (p_q[W-1:1] != '0), op: ALU_MUL};
        alu_x   = x_q;
        alu_y   = x_q;
      end
      S_POW_XMUL: if (alu_sts.done) x_d = alu_lo;
      S_DONE: ;
      default: ;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    a_q    <= a_d;
    b_q    <= b_d;
    x_q    <= x_d;
    y_q    <= y_d;
    p_q    <= p_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = (state_q == S_DONE);
  assign out_o.result = res_q;

endmodule
`default_nettype wire

### rtl/core/intu_alu.sv
`default_nettype none
`include "integer_number_theory_unit_defines.svh"
// shared one-bit-per-cycle multiply / restoring divide unit
module intu_alu import intu_pkg::*; #(
  parameter int unsigned W = DATA_WIDTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire alu_req_t     req_i,
  input  wire logic [W-1:0] x_i,
  input  wire logic [W-1:0] y_i,
  output      alu_sts_t     sts_o,
  output      logic [W-1:0] lo_o,
  output      logic [W-1:0] rem_o
);

  localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  alu_op_e          op_q;
  logic [W-1:0]     q_q, q_d;
  logic [W-1:0]     r_q, r_d;
  logic [W-1:0]     y_q;

  logic           sub;
  logic           take;
  logic [W+1:0]   tmp, opa, opb, sum;

  // one add/subtract per cycle, shared by both operations
  always_comb begin
    sub  = (op_q == ALU_DIV);
    tmp  = {1'b0, r_q, q_q[W-1]};
    opa  = sub ? tmp : {2'b00, r_q[W-2:0], 1'b0};
    opb  = (sub || q_q[W-1]) ? {2'b00, y_q} : '0;
    sum  = opa + (sub ? ~opb : opb) + (W+2)'(sub);
    take = sub & ~sum[W+1];
    r_d  = (sub && !take) ? tmp[W-1:0] : sum[W-1:0];
    q_d  = {q_q[W-2:0], take};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      op_q <= req_i.op;
      q_q  <= x_i;
      y_q  <= y_i;
      r_q  <= '0;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign lo_o  = (op_q == ALU_MUL) ? r_q : q_q;
  assign rem_o = r_q;

  `INTU_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, req_i.start && !busy_q, busy_q, "start did not set busy")
  `INTU_ASSERT(a_done_idle, clk_i, rst_ni, done_q |-> !busy_q, "done while busy")
  `INTU_ASSERT_NEXT(a_last_done, clk_i, rst_ni, busy_q && cnt_q == CNT_LAST, done_q, "missing done")

endmodule
`default_nettype wire
